@@ sv/fbfl_pkg.sv @@
// Shared types and codes for the fixed block free list allocator.
// No dependencies; the other files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package fbfl_pkg;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  granted_block;
    logic [8:0]  avail_count;
    logic [8:0]  used_count;
    logic [8:0]  high_water;
    logic [31:0] acquire_total;
    logic [31:0] release_total;
  } rsp_t;

  // Link memory write port
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } link_wr_t;

  // Pool (re)initialization request
  typedef struct packed {
    logic       wr;
    logic [8:0] capacity;
  } cfg_t;

endpackage

@@ sv/fbfl_ifs.sv @@
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on nothing but the field widths of the allocator.
`timescale 1ns / 1ps

interface fbfl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] block_index;
  modport source (output valid, output opcode, output block_index, input ready);
  modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

interface fbfl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  granted_block;
  logic [8:0]  avail_count;
  logic [8:0]  used_count;
  logic [8:0]  high_water;
  logic [31:0] acquire_total;
  logic [31:0] release_total;
  modport source (output valid, output status, output granted_block, output avail_count,
                  output used_count, output high_water, output acquire_total,
                  output release_total, input ready);
  modport sink   (input valid, input status, input granted_block, input avail_count,
                  input used_count, input high_water, input acquire_total,
                  input release_total, output ready);
endinterface

interface fbfl_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] pool_capacity;
  modport source (output valid, output pool_capacity, input ready);
  modport sink   (input valid, input pool_capacity, output ready);
endinterface

@@ sv/fbfl_link_mem.sv @@
// Link memory: one write port, one registered read port, write-first on collision.
// Uses fbfl_pkg::link_wr_t.
`timescale 1ns / 1ps

module fbfl_link_mem #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  fbfl_pkg::link_wr_t wr,
  input  logic [7:0]         rd_addr,
  output logic [7:0]         rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (wr.en && (wr.addr[AW-1:0] == rd_addr[AW-1:0])) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/fbfl_core.sv @@
// Pool state: free stack cache (top, second, third via link memory) and counters.
// Uses fbfl_pkg types and codes; instantiates fbfl_link_mem.
`timescale 1ns / 1ps

module fbfl_core #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fbfl_pkg::cfg_t cfg,
  input  logic           go,
  input  fbfl_pkg::req_t req,
  output fbfl_pkg::rsp_t rsp
);

  localparam int DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam logic [8:0] CAP_MAX = 9'(DEPTH);

  logic [8:0]  cap_r,    cap_nxt;
  logic [8:0]  depth_r,  depth_nxt;
  logic [8:0]  fresh_r,  fresh_nxt;
  logic [8:0]  inuse_r,  inuse_nxt;
  logic [8:0]  peak_r,   peak_nxt;
  logic [31:0] acq_r,    acq_nxt;
  logic [31:0] rel_r,    rel_nxt;
  logic [7:0]  top_r,    top_nxt;
  logic [7:0]  sec_r,    sec_nxt;
  logic [7:0]  third;
  logic [8:0]  free_w;
  logic [8:0]  fresh_dec;
  logic [8:0]  cap_clip;
  logic [1:0]  status;
  logic [7:0]  granted;
  fbfl_pkg::link_wr_t link_wr;

  // sec_r always mirrors link[top_r]; third mirrors link[sec_r], re-read every cycle
  fbfl_link_mem #(.DEPTH(DEPTH)) u_link (
    .clk     (clk),
    .wr      (link_wr),
    .rd_addr (sec_nxt),
    .rd_data (third)
  );

  assign free_w    = depth_r + fresh_r;
  assign fresh_dec = fresh_r - 9'd1;
  assign cap_clip  = (cfg.capacity > CAP_MAX) ? CAP_MAX : cfg.capacity;

  always_comb begin
    cap_nxt   = cap_r;
    depth_nxt = depth_r;
    fresh_nxt = fresh_r;
    inuse_nxt = inuse_r;
    peak_nxt  = peak_r;
    acq_nxt   = acq_r;
    rel_nxt   = rel_r;
    top_nxt   = top_r;
    sec_nxt   = sec_r;
    status    = fbfl_pkg::ST_QUERY;
    granted   = 8'd0;
    link_wr   = '0;
    if (cfg.wr) begin
      cap_nxt   = cap_clip;
      depth_nxt = 9'd0;
      fresh_nxt = cap_clip;
      inuse_nxt = 9'd0;
      peak_nxt  = 9'd0;
      acq_nxt   = 32'd0;
      rel_nxt   = 32'd0;
      top_nxt   = 8'd0;
    end else if (go) begin
      unique case (req.opcode)
        fbfl_pkg::OP_ACQUIRE: begin
          if (depth_r != 9'd0) begin
            granted   = top_r;
            top_nxt   = sec_r;
            sec_nxt   = third;
            depth_nxt = depth_r - 9'd1;
            status    = fbfl_pkg::ST_DONE;
          end else if (fresh_r != 9'd0) begin
            fresh_nxt = fresh_dec;
            granted   = fresh_dec[7:0];
            status    = fbfl_pkg::ST_DONE;
          end else begin
            status = fbfl_pkg::ST_EMPTY;
          end
          if (status == fbfl_pkg::ST_DONE) begin
            inuse_nxt = inuse_r + 9'd1;
            acq_nxt   = acq_r + 32'd1;
            if (inuse_nxt > peak_r) begin
              peak_nxt = inuse_nxt;
            end
          end
        end
        fbfl_pkg::OP_RELEASE: begin
          // push only an in-range block while the pool is not already full
          if (({1'b0, req.block_index} < cap_r) && (free_w < cap_r)) begin
            link_wr.en   = 1'b1;
            link_wr.addr = req.block_index;
            link_wr.data = top_r;
            top_nxt      = req.block_index;
            sec_nxt      = top_r;
            depth_nxt    = depth_r + 9'd1;
          end
          if (inuse_r != 9'd0) begin
            inuse_nxt = inuse_r - 9'd1;
          end
          rel_nxt = rel_r + 32'd1;
          status  = fbfl_pkg::ST_DONE;
        end
        default: begin
          status = fbfl_pkg::ST_QUERY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_MAX;
      depth_r <= 9'd0;
      fresh_r <= CAP_MAX;
      inuse_r <= 9'd0;
      peak_r  <= 9'd0;
      acq_r   <= 32'd0;
      rel_r   <= 32'd0;
    end else begin
      cap_r   <= cap_nxt;
      depth_r <= depth_nxt;
      fresh_r <= fresh_nxt;
      inuse_r <= inuse_nxt;
      peak_r  <= peak_nxt;
      acq_r   <= acq_nxt;
      rel_r   <= rel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= 8'd0;
      sec_r <= 8'd0;
    end else begin
      top_r <= top_nxt;
      sec_r <= sec_nxt;
    end
  end

  always_comb begin
    rsp.status        = status;
    rsp.granted_block = granted;
    rsp.avail_count   = depth_nxt + fresh_nxt;
    rsp.used_count    = inuse_nxt;
    rsp.high_water    = peak_nxt;
    rsp.acquire_total = acq_nxt;
    rsp.release_total = rel_nxt;
  end

endmodule

@@ sv/fixed_block_free_list_allocator.sv @@
// Fixed block free list allocator top level: request register, result register, handshakes.
// Depends on fbfl_pkg, the fbfl_ifs channel interfaces and fbfl_core.
`timescale 1ns / 1ps

// Pool of equal blocks named 0..capacity-1. An acquire transfer returns a block index,
// a release transfer gives one back, a query transfer only reports the counts. Released
// blocks are reused last-in first-out; blocks never handed out are served afterwards,
// counting down from capacity-1. Every request yields exactly one result transfer.
// Throughput is one request per clock while the result side keeps draining: a request is
// registered on acceptance and handled once the result register is free or being drained,
// which loads its result into the output register and raises result valid. The link
// memory has a single read port, the limiting resource; the top two stack entries are
// cached in flops and the third is re-read from the memory every cycle so back-to-back
// pops never wait on it. A write on the cfg channel (always ready) sets the capacity,
// clipped to MAX_BLOCKS and to 256, and restarts the pool; only issue it while no
// request is outstanding. No clearing pass is needed after reset.
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  fbfl_in_if.sink    in_ch,
  fbfl_out_if.source out_ch,
  fbfl_cfg_if.sink   cfg_ch
);

  logic           req_valid_r, req_valid_nxt;
  fbfl_pkg::req_t req_r;
  logic           out_valid_r, out_valid_nxt;
  fbfl_pkg::rsp_t out_r;
  fbfl_pkg::rsp_t rsp;
  fbfl_pkg::cfg_t cfg;
  logic           proceed;
  logic           go;
  logic           in_xfer;

  // Result register free this cycle, or being drained
  assign proceed = !out_valid_r || out_ch.ready;
  assign go      = req_valid_r && proceed;
  assign in_ch.ready = !req_valid_r || proceed;
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;
  assign cfg.wr       = cfg_ch.valid;
  assign cfg.capacity = cfg_ch.pool_capacity;

  fbfl_core #(.MAX_BLOCKS(MAX_BLOCKS)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .go    (go),
    .req   (req_r),
    .rsp   (rsp)
  );

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_xfer) begin
      req_valid_nxt = 1'b1;
    end else if (go) begin
      req_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r.opcode      <= in_ch.opcode;
      req_r.block_index <= in_ch.block_index;
    end
    if (go) begin
      out_r <= rsp;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.granted_block = out_r.granted_block;
  assign out_ch.avail_count   = out_r.avail_count;
  assign out_ch.used_count    = out_r.used_count;
  assign out_ch.high_water    = out_r.high_water;
  assign out_ch.acquire_total = out_r.acquire_total;
  assign out_ch.release_total = out_r.release_total;

  // Empty-pool result reports no block and no free count
  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == fbfl_pkg::ST_EMPTY) |->
      (out_r.granted_block == 8'd0 && out_r.avail_count == 9'd0))
    else $error("empty status with nonzero grant or free count");

  // Peak never trails the live used count
  a_peak_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.high_water >= out_r.used_count))
    else $error("high water below used count");

  // A handled request always lands in the result register
  a_go_lands: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("handled request produced no result");

endmodule

@@ verif/fixed_block_free_list_allocator_tb.sv @@
// Self-checking testbench for fixed_block_free_list_allocator: predicts every result transfer.
// Depends on fbfl_pkg, the fbfl_ifs channel interfaces and the allocator RTL.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_tb;

  // Opcode 3 is unused by the block and must behave as a query.
  localparam logic [1:0] OP_SPARE = 2'd3;
  // Cycles without any transfer on any channel before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // Length of the forced receiver hold-off used to back the block up.
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  // Cycles to let pass after the last result, with margin.
  localparam int unsigned SETTLE_CYCLES = 6;

  logic clk;
  logic rst_n;

  fbfl_in_if  req_if ();
  fbfl_out_if rsp_if ();
  fbfl_cfg_if cap_if ();

  fixed_block_free_list_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if),
    .cfg_ch (cap_if)
  );

  // ---------------------------------------------------------------------------
  // Pool shadow: mirrors the allocator state so every accepted request can be
  // turned into the result it must produce.
  // ---------------------------------------------------------------------------
  bit [7:0]    pool_links [0:255];  // block below each stacked block
  bit [7:0]    stk_top;
  bit [8:0]    stk_depth;
  bit [8:0]    fresh_left;          // never-issued blocks, served top-down
  bit [8:0]    busy_blocks;
  bit [8:0]    peak_busy;
  bit [31:0]   acq_count;
  bit [31:0]   rel_count;
  bit [8:0]    eff_cap;

  fbfl_pkg::rsp_t pending_results [$];  // predicted results, oldest first
  bit [7:0]    held_blocks [$];      // blocks granted and not yet given back
  int unsigned fail_count = 0;
  int unsigned burst_left;
  int unsigned hold_requests = 0;    // long hold-offs asked for by the tests

  // Capacity write restarts the pool; the link memory keeps its contents.
  function automatic void restart_pool(logic [8:0] cap_value);
    eff_cap     = (cap_value > 9'd256) ? 9'd256 : cap_value;
    stk_top     = '0;
    stk_depth   = '0;
    fresh_left  = eff_cap;
    busy_blocks = '0;
    peak_busy   = '0;
    acq_count   = '0;
    rel_count   = '0;
    held_blocks.delete();
  endfunction

  function automatic fbfl_pkg::rsp_t next_pool_result(logic [1:0] op, logic [7:0] idx);
    fbfl_pkg::rsp_t r;
    r        = '0;
    r.status = fbfl_pkg::ST_QUERY;
    case (op)
      fbfl_pkg::OP_ACQUIRE: begin
        if (stk_depth != 0) begin
          r.granted_block = stk_top;
          stk_top         = pool_links[stk_top];
          stk_depth--;
          r.status        = fbfl_pkg::ST_DONE;
        end else if (fresh_left != 0) begin
          fresh_left--;
          r.granted_block = fresh_left[7:0];
          r.status        = fbfl_pkg::ST_DONE;
        end else begin
          r.status = fbfl_pkg::ST_EMPTY;
        end
        if (r.status == fbfl_pkg::ST_DONE) begin
          busy_blocks++;
          acq_count++;
          if (busy_blocks > peak_busy) peak_busy = busy_blocks;
          held_blocks = {held_blocks, r.granted_block};
        end
      end
      fbfl_pkg::OP_RELEASE: begin
        // Out-of-range index or a full free list: count it, push nothing.
        if ({1'b0, idx} < eff_cap && stk_depth + fresh_left < eff_cap) begin
          pool_links[idx] = stk_top;
          stk_top         = idx;
          stk_depth++;
        end
        if (busy_blocks != 0) busy_blocks--;
        rel_count++;
        r.status = fbfl_pkg::ST_DONE;
      end
      default: ;
    endcase
    r.avail_count   = stk_depth + fresh_left;
    r.used_count    = busy_blocks;
    r.high_water    = peak_busy;
    r.acquire_total = acq_count;
    r.release_total = rel_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and the sender side
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One request transfer. The sender works in bursts; a gap is inserted only
  // when a burst runs out, so valid stays high across back-to-back requests.
  task automatic send_request(input logic [1:0] op, input logic [7:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                              : $urandom_range(1, 10);
      gap = $urandom_range(1, 6);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.block_index <= idx;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results = {pending_results, next_pool_result(op, idx)};
  endtask

  // Drop valid in the step of the last transfer, then wait for every result.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Capacity writes only happen with the block idle.
  task automatic set_capacity(input logic [8:0] cap_value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cap_if.valid         <= 1'b1;
    cap_if.pool_capacity <= cap_value;
    @(posedge clk);
    while (!cap_if.ready) @(posedge clk);
    cap_if.valid <= 1'b0;
    restart_pool(cap_value);
  endtask

  // Mostly well-formed traffic (acquire / give back a held block) with some
  // stray releases, queries and the spare opcode mixed in.
  task automatic send_mixed_request();
    int unsigned pick;
    int unsigned k;
    bit [7:0]    blk;
    pick = $urandom_range(0, 99);
    if (pick < 80 && pick >= 45 && held_blocks.size() != 0) begin
      k   = $urandom_range(0, held_blocks.size() - 1);
      blk = held_blocks[k];
      held_blocks.delete(k);
      send_request(fbfl_pkg::OP_RELEASE, blk);
    end else if (pick < 80) begin
      send_request(fbfl_pkg::OP_ACQUIRE, 8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      // Stray release: may be out of range, a double free or a no-op.
      send_request(fbfl_pkg::OP_RELEASE, 8'($urandom_range(0, 255)));
    end else if (pick < 96) begin
      send_request(fbfl_pkg::OP_QUERY, 8'($urandom_range(0, 255)));
    end else begin
      send_request(OP_SPARE, 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a stall pattern that is re-chosen at random whenever its
  // run ends, unless a long hold-off has been requested.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  int unsigned holds_started = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  always @(posedge clk) begin
    if (holds_started != hold_requests) begin
      holds_started = hold_requests;
      hold_left     = LONG_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 80);
      end
      mode_left--;
      case (stall_mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
        2:       rsp_if.ready <= 1'($urandom_range(0, 1));
        default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    fbfl_pkg::rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result transfer with nothing outstanding: status 0x%0h", rsp_if.status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_if.status));
        check_field("granted_block", 32'(want.granted_block), 32'(rsp_if.granted_block));
        check_field("avail_count", 32'(want.avail_count), 32'(rsp_if.avail_count));
        check_field("used_count", 32'(want.used_count), 32'(rsp_if.used_count));
        check_field("high_water", 32'(want.high_water), 32'(rsp_if.high_water));
        check_field("acquire_total", want.acquire_total, rsp_if.acquire_total);
        check_field("release_total", want.release_total, rsp_if.release_total);
      end
    end
  end

  // Hang detector: any transfer on any channel restarts the count.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cap_if.valid && cap_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases: queries, the spare opcode, release with everything free,
  // stack reuse, exhaustion, out-of-range release, zero and clipped capacity.
  task automatic test_directed();
    send_request(fbfl_pkg::OP_QUERY,   8'h00);
    send_request(OP_SPARE,             8'hFF);
    send_request(fbfl_pkg::OP_RELEASE, 8'h00);  // all free and nothing in use
    send_request(fbfl_pkg::OP_ACQUIRE, 8'h55);  // fresh block 255
    send_request(fbfl_pkg::OP_ACQUIRE, 8'hAA);  // fresh block 254
    send_request(fbfl_pkg::OP_RELEASE, 8'hFF);
    send_request(fbfl_pkg::OP_ACQUIRE, 8'h00);  // 255 back off the stack
    send_request(fbfl_pkg::OP_RELEASE, 8'hAA);  // never-granted block still gets pushed
    send_request(fbfl_pkg::OP_ACQUIRE, 8'h00);

    set_capacity(9'd2);
    send_request(fbfl_pkg::OP_ACQUIRE, 8'h00);
    send_request(fbfl_pkg::OP_ACQUIRE, 8'h00);
    send_request(fbfl_pkg::OP_ACQUIRE, 8'h00);  // empty pool
    send_request(fbfl_pkg::OP_RELEASE, 8'hC8);  // index beyond capacity
    send_request(fbfl_pkg::OP_RELEASE, 8'h00);
    send_request(fbfl_pkg::OP_ACQUIRE, 8'hFF);
    send_request(fbfl_pkg::OP_RELEASE, 8'h01);
    send_request(fbfl_pkg::OP_RELEASE, 8'h00);
    send_request(fbfl_pkg::OP_RELEASE, 8'h01);  // free count already at capacity
    send_request(fbfl_pkg::OP_QUERY,   8'h55);

    set_capacity(9'd0);
    send_request(fbfl_pkg::OP_ACQUIRE, 8'h00);
    send_request(fbfl_pkg::OP_RELEASE, 8'h00);
    send_request(OP_SPARE,             8'h00);

    set_capacity(9'd511);             // clipped to 256
    send_request(fbfl_pkg::OP_ACQUIRE, 8'h00);
    send_request(fbfl_pkg::OP_RELEASE, 8'hFF);
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering acquires, so the block
  // backs up and stalls its input; the pool is then run dry and mixed traffic gives some blocks back.
  task automatic test_backpressure_fill();
    set_capacity(9'd256);
    hold_requests++;
    repeat (260) send_request(fbfl_pkg::OP_ACQUIRE, 8'($urandom_range(0, 255)));
    repeat (40) send_mixed_request();
    // Sender pauses until the block has emptied completely.
    drain_results();
  endtask

  // Random traffic over a range of pool sizes, small ones dominating so the
  // empty-pool and full-free-list cases come up often.
  task automatic test_random_pool_sizes();
    logic [8:0] sizes [8];
    sizes = '{9'd1, 9'd3, 9'd8, 9'd17, 9'd64, 9'd300, 9'd5, 9'd256};
    foreach (sizes[i]) begin
      set_capacity(sizes[i]);
      repeat (40) send_mixed_request();
    end
    drain_results();
  endtask

  initial begin
    rst_n                <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.opcode        <= fbfl_pkg::OP_QUERY;
    req_if.block_index   <= '0;
    cap_if.valid         <= 1'b0;
    cap_if.pool_capacity <= '0;
    burst_left = 0;
    restart_pool(9'd256);             // reset capacity
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure_fill();
    test_random_pool_sizes();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/fbfl_pkg.sv
sv/fbfl_ifs.sv
sv/fbfl_link_mem.sv
sv/fbfl_core.sv
sv/fixed_block_free_list_allocator.sv
verif/fixed_block_free_list_allocator_tb.sv
